### design/acrf_pkg.sv
// Shared types and codes for the admission-controlled request queue.
`default_nettype none
package acrf_pkg;
    localparam int LIMIT_W = 9;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_POPPED    = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_REMOVED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_DROP   = 2'd1,
        CM_ROTATE = 2'd2,
        CM_LOAD   = 2'd3
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       hit;   // this cell is the tail / write target
    } cell_ctrl_t;

    typedef struct packed {
        logic [15:0] client;
        logic [15:0] peer;
        logic [31:0] connection;
        logic [7:0]  request_kind;
        logic [63:0] request_id;
    } entry_t;

    typedef enum logic {
        CFG_PER_CONN = 1'b0,
        CFG_PENDING  = 1'b1
    } cfg_idx_t;
endpackage
`default_nettype wire

### design/acrf_cell.sv
// One queue slot: takes its neighbor's entry, the head entry or a new entry.
`default_nettype none
module acrf_cell (
    input  wire logic                    aclk,
    input  wire acrf_pkg::cell_ctrl_t    ctrl,
    input  wire acrf_pkg::entry_t        nb_i,
    input  wire acrf_pkg::entry_t        head_i,
    input  wire acrf_pkg::entry_t        load_i,
    output acrf_pkg::entry_t             q_o
);
    import acrf_pkg::*;

    entry_t q_reg;

    always_ff @(posedge aclk) begin
        unique case (ctrl.mode)
            CM_HOLD:   q_reg <= q_reg;
            CM_DROP:   q_reg <= nb_i;
            CM_ROTATE: q_reg <= ctrl.hit ? head_i : nb_i;
            CM_LOAD:   q_reg <= ctrl.hit ? load_i : q_reg;
        endcase
    end

    assign q_o = q_reg;
endmodule
`default_nettype wire

### design/admission_controlled_request_fifo.sv
// Top level: request queue as a row of cells with a scan sequencer.
// Push and remove take one scan step per pending entry (a rotation, or a drop
// on a remove that matches), then a decision; pop, unknown operations and
// pushes with a zero client, peer or id skip the scan and go straight to done.
// One item at a time: no new item is taken until the result has been taken.
// Reset (aresetn low, sync)
// empties the queue, sets the limits to 16 and 256; slots are not cleared.
`default_nettype none
module admission_controlled_request_fifo #(
    parameter int DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [15:0] s_client_handle,
    input  wire logic [15:0] s_peer_handle,
    input  wire logic [31:0] s_connection_number,
    input  wire logic [7:0]  s_request_kind,
    input  wire logic [63:0] s_request_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [15:0]      m_out_client,
    output logic [15:0]      m_out_peer,
    output logic [31:0]      m_out_connection,
    output logic [7:0]       m_out_request_kind,
    output logic [63:0]      m_out_request_id,
    output logic [8:0]       m_pending_count
);
    import acrf_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t              state_reg;
    op_t                 op_reg;
    entry_t              req_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       steps_reg;
    logic [CW-1:0]       same_reg;
    logic                dup_reg;
    logic [LIMIT_W-1:0]  per_conn_reg;
    logic [LIMIT_W-1:0]  pending_reg;
    logic                m_valid_reg;
    status_t             m_status_reg;
    entry_t              m_ent_reg;
    logic [CW-1:0]       m_count_reg;

    entry_t              cells [DEPTH];
    entry_t              head;
    entry_t              in_ent;
    cell_mode_t          mode;
    logic [AW-1:0]       tgt;
    logic                accept;
    logic                head_same;
    logic                admit;

    assign head   = cells[0];
    assign in_ent = '{s_client_handle, s_peer_handle, s_connection_number,
                      s_request_kind, s_request_id};
    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign accept  = s_valid && s_ready;

    assign head_same = (head.client == req_reg.client) && (head.peer == req_reg.peer)
                    && (head.connection == req_reg.connection);

    // admission after the scan: no duplicate, limits, then capacity
    assign admit = !dup_reg
                && (CMPW'(same_reg) < CMPW'(per_conn_reg))
                && (CMPW'(count_reg) < CMPW'(pending_reg))
                && (CMPW'(count_reg) < CMPW'(DEPTH));

    // cell row control
    always_comb begin
        mode = CM_HOLD;
        tgt  = AW'(count_reg - CW'(1));
        priority case (state_reg)
            S_IDLE: begin
                if (accept && op_t'(s_kind) == OP_POP && count_reg != '0)
                    mode = CM_DROP;
            end
            S_SCAN: begin
                if (steps_reg != '0) begin
                    if (op_reg == OP_REMOVE && head.client == req_reg.client)
                        mode = CM_DROP;
                    else
                        mode = CM_ROTATE;
                end else if (op_reg == OP_PUSH && admit) begin
                    mode = CM_LOAD;
                    tgt  = AW'(count_reg);
                end
            end
            default: mode = CM_HOLD;
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_ctrl_t ctrl;
        assign ctrl.mode = mode;
        assign ctrl.hit  = (tgt == AW'(i));
        acrf_cell u_cell (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .nb_i   ((i == DEPTH - 1) ? cells[i] : cells[(i + 1) % DEPTH]),
            .head_i (head),
            .load_i (req_reg),
            .q_o    (cells[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            per_conn_reg <= LIMIT_W'(16);
            pending_reg  <= LIMIT_W'(256);
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_PER_CONN: per_conn_reg <= cfg_wdata;
                    CFG_PENDING:  pending_reg  <= cfg_wdata;
                endcase
            end
            if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= op_t'(s_kind);
                        req_reg   <= in_ent;
                        steps_reg <= count_reg;
                        same_reg  <= '0;
                        dup_reg   <= 1'b0;
                        // entry fields only on a pop that finds an entry
                        m_ent_reg <= (op_t'(s_kind) == OP_POP && count_reg != '0)
                                     ? head : '0;
                        unique case (op_t'(s_kind))
                            OP_PUSH: begin
                                if (s_client_handle == '0 || s_peer_handle == '0
                                    || s_request_id == '0) begin
                                    m_status_reg <= ST_REJECTED;
                                    m_count_reg  <= count_reg;
                                    state_reg    <= S_DONE;
                                end else begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            OP_REMOVE: state_reg <= S_SCAN;
                            OP_POP: begin
                                if (count_reg == '0) begin
                                    m_status_reg <= ST_EMPTY;
                                    m_count_reg  <= count_reg;
                                end else begin
                                    m_status_reg <= ST_POPPED;
                                    m_count_reg  <= count_reg - CW'(1);
                                    count_reg    <= count_reg - CW'(1);
                                end
                                state_reg <= S_DONE;
                            end
                            OP_NONE: begin
                                m_status_reg <= ST_REJECTED;
                                m_count_reg  <= count_reg;
                                state_reg    <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (steps_reg != '0) begin
                        steps_reg <= steps_reg - CW'(1);
                        if (op_reg == OP_REMOVE) begin
                            if (head.client == req_reg.client)
                                count_reg <= count_reg - CW'(1);
                        end else if (head_same) begin
                            same_reg <= same_reg + CW'(1);
                            if (head.request_kind == req_reg.request_kind
                                && head.request_id == req_reg.request_id)
                                dup_reg <= 1'b1;
                        end
                    end else begin
                        state_reg   <= S_DONE;
                        m_count_reg <= (op_reg == OP_PUSH && admit)
                                       ? count_reg + CW'(1) : count_reg;
                        if (op_reg == OP_REMOVE) begin
                            m_status_reg <= ST_REMOVED;
                        end else if (dup_reg) begin
                            m_status_reg <= ST_DUPLICATE;
                        end else if (admit) begin
                            m_status_reg <= ST_ADDED;
                            count_reg    <= count_reg + CW'(1);
                        end else begin
                            m_status_reg <= ST_REJECTED;
                        end
                    end
                end
                S_DONE: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic [CMPW-1:0] m_count_wide;
    assign m_count_wide = CMPW'(m_count_reg);

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_out_client       = m_ent_reg.client;
    assign m_out_peer         = m_ent_reg.peer;
    assign m_out_connection   = m_ent_reg.connection;
    assign m_out_request_kind = m_ent_reg.request_kind;
    assign m_out_request_id   = m_ent_reg.request_id;
    assign m_pending_count    = m_count_wide[8:0];
endmodule
`default_nettype wire

### design/acrf_checker.sv
// Port-level checks for the request queue, bound to the top level.
`default_nettype none
module acrf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [15:0] m_out_client,
    input wire logic [63:0] m_out_request_id,
    input wire logic [8:0]  m_pending_count
);
    import acrf_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while result pending");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_POPPED |-> m_out_client == '0 && m_out_request_id == '0)
        else $error("entry fields nonzero on non-pop result");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_pending_count == '0)
        else $error("empty reported with entries held");
endmodule

bind admission_controlled_request_fifo acrf_checker u_acrf_checker (.*);
`default_nettype wire

### tb/sv/testbench.sv
// Testbench for the admission-controlled request queue: directed and random items, self-checked.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import acrf_pkg::*;

    localparam int QDEPTH      = 256;
    localparam int IDLE_LIMIT  = 20000;   // cycles with neither channel moving before giving up
    localparam int DRAIN_WAIT  = QDEPTH + 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] client;
        logic [15:0] peer;
        logic [31:0] conn;
        logic [7:0]  rkind;
        logic [63:0] rid;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] client;
        logic [15:0] peer;
        logic [31:0] conn;
        logic [7:0]  rkind;
        logic [63:0] rid;
        logic [8:0]  count;
    } resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [15:0] s_client_handle = '0;
    logic [15:0] s_peer_handle = '0;
    logic [31:0] s_connection_number = '0;
    logic [7:0]  s_request_kind = '0;
    logic [63:0] s_request_id = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_out_client;
    logic [15:0] m_out_peer;
    logic [31:0] m_out_connection;
    logic [7:0]  m_out_request_kind;
    logic [63:0] m_out_request_id;
    logic [8:0]  m_pending_count;

    admission_controlled_request_fifo #(.DEPTH(QDEPTH)) u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: the queue as the block should hold it
    entry_t      queue_model[$];
    logic [8:0]  conn_limit;
    logic [8:0]  total_limit;
    resp_t       expected_q[$];

    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          sink_noidle = 1'b0;    // long stretch without back-pressure
    bit          sink_hold = 1'b0;      // receiver holds off entirely
    bit          src_noidle = 1'b0;

    function automatic resp_t predict_queue_op(req_t r);
        resp_t  o;
        entry_t e;
        int     same;
        bit     dup;
        o = '0;
        case (op_t'(r.kind))
            OP_PUSH: begin
                if (r.client == 0 || r.peer == 0 || r.rid == 0) begin
                    o.status = ST_REJECTED;
                end else begin
                    same = 0;
                    dup = 1'b0;
                    foreach (queue_model[i]) begin
                        if (queue_model[i].client == r.client && queue_model[i].peer == r.peer
                            && queue_model[i].connection == r.conn) begin
                            same++;
                            if (queue_model[i].request_kind == r.rkind
                                && queue_model[i].request_id == r.rid)
                                dup = 1'b1;
                        end
                    end
                    if (dup) begin
                        o.status = ST_DUPLICATE;
                    end else if (same >= conn_limit || queue_model.size() >= total_limit
                                 || queue_model.size() >= QDEPTH) begin
                        o.status = ST_REJECTED;
                    end else begin
                        e.client = r.client;
                        e.peer = r.peer;
                        e.connection = r.conn;
                        e.request_kind = r.rkind;
                        e.request_id = r.rid;
                        queue_model.push_back(e);
                        o.status = ST_ADDED;
                    end
                end
            end
            OP_POP: begin
                if (queue_model.size() == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    e = queue_model.pop_front();
                    o.status = ST_POPPED;
                    o.client = e.client;
                    o.peer = e.peer;
                    o.conn = e.connection;
                    o.rkind = e.request_kind;
                    o.rid = e.request_id;
                end
            end
            OP_REMOVE: begin
                for (int i = queue_model.size() - 1; i >= 0; i--)
                    if (queue_model[i].client == r.client) queue_model.delete(i);
                o.status = ST_REMOVED;
            end
            default: o.status = ST_REJECTED;
        endcase
        o.count = 9'(queue_model.size());
        return o;
    endfunction

    // one item on the input channel; prediction is made at acceptance
    task automatic send_request(req_t r);
        @(negedge aclk);
        if (!src_noidle)
            while ($urandom_range(99) < 26) @(negedge aclk);
        s_valid <= 1'b1;
        s_kind <= r.kind;
        s_client_handle <= r.client;
        s_peer_handle <= r.peer;
        s_connection_number <= r.conn;
        s_request_kind <= r.rkind;
        s_request_id <= r.rid;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(predict_queue_op(r));
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic req_t mk(logic [1:0] k, logic [15:0] c, logic [15:0] p,
                                logic [31:0] n, logic [7:0] rk, logic [63:0] id);
        req_t r;
        r.kind = k; r.client = c; r.peer = p; r.conn = n; r.rkind = rk; r.rid = id;
        return r;
    endfunction

    task automatic drain_results();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_limit(cfg_idx_t idx, logic [8:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_PER_CONN) conn_limit = val;
        else total_limit = val;
    endtask

    // receiver side: random back-pressure unless held off or kept ready, sampled at the rising edge
    always @(negedge aclk) begin
        if (sink_hold) m_ready <= 1'b0;
        else if (sink_noidle) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 26);
    end

    always @(posedge aclk) begin
        resp_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_out_client, m_out_peer, m_out_connection,
                   m_out_request_kind, m_out_request_id, m_pending_count};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // watchdog: cycles where neither channel moves
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || sink_hold) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // random push with small client/peer/conn pools so duplicates and limits hit
    function automatic req_t rand_push();
        req_t r;
        r = mk(OP_PUSH, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
               32'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
               64'($urandom_range(1, 6)));
        if ($urandom_range(9) == 0) begin
            r.client = 16'($urandom);
            r.peer = 16'($urandom);
            r.conn = $urandom;
            r.rkind = 8'($urandom);
            r.rid = {$urandom, $urandom};
        end
        if ($urandom_range(29) == 0) r.client = 0;
        if ($urandom_range(29) == 0) r.peer = 0;
        if ($urandom_range(29) == 0) r.rid = 0;
        return r;
    endfunction

    function automatic req_t rand_request();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return rand_push();
        if (sel < 88) return mk(OP_POP, 16'($urandom), 16'($urandom), $urandom,
                                8'($urandom), {$urandom, $urandom});
        if (sel < 97) return mk(OP_REMOVE, 16'($urandom_range(0, 5)), 16'($urandom), $urandom,
                                8'($urandom), {$urandom, $urandom});
        return mk(OP_NONE, 16'($urandom), 16'($urandom), $urandom, 8'($urandom),
                  {$urandom, $urandom});
    endfunction

    task automatic test_directed();
        send_request(mk(OP_POP, 0, 0, 0, 0, 0));                 // pop when empty
        send_request(mk(OP_PUSH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, '1));
        send_request(mk(OP_PUSH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, '1)); // duplicate
        send_request(mk(OP_PUSH, 0, 1, 1, 1, 1));                // zero client
        send_request(mk(OP_PUSH, 1, 0, 1, 1, 1));                // zero peer
        send_request(mk(OP_PUSH, 1, 1, 1, 1, 0));                // zero id
        send_request(mk(OP_PUSH, 1, 1, 0, 0, 1));
        send_request(mk(OP_PUSH, 1, 2, 0, 0, 1));
        send_request(mk(OP_PUSH, 2, 1, 0, 0, 1));
        send_request(mk(OP_NONE, 1, 1, 1, 1, 1));                // unknown operation
        send_request(mk(OP_REMOVE, 0, 0, 0, 0, 0));              // remove client zero
        send_request(mk(OP_REMOVE, 1, 0, 0, 0, 0));
        send_request(mk(OP_POP, '1, '1, '1, '1, '1));
        send_request(mk(OP_POP, 0, 0, 0, 0, 0));
        send_request(mk(OP_POP, 0, 0, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_limits();
        // per-connection limit 1, then duplicate while limit is reached
        write_limit(CFG_PER_CONN, 9'd1);
        send_request(mk(OP_PUSH, 3, 3, 3, 0, 1));
        send_request(mk(OP_PUSH, 3, 3, 3, 0, 2));
        send_request(mk(OP_PUSH, 3, 3, 3, 0, 1));
        drain_results();
        write_limit(CFG_PER_CONN, 9'd0);                        // zero limit rejects all
        write_limit(CFG_PENDING, 9'd0);
        send_request(mk(OP_PUSH, 4, 4, 4, 4, 4));
        drain_results();
        write_limit(CFG_PER_CONN, 9'd511);
        write_limit(CFG_PENDING, 9'd2);
        send_request(mk(OP_PUSH, 5, 5, 5, 5, 5));
        send_request(mk(OP_PUSH, 6, 5, 5, 5, 5));
        send_request(mk(OP_REMOVE, 3, 0, 0, 0, 0));
        send_request(mk(OP_REMOVE, 5, 0, 0, 0, 0));
        send_request(mk(OP_REMOVE, 6, 0, 0, 0, 0));
        drain_results();
    endtask

    // fill past capacity with pending limit above depth; receiver held off
    task automatic test_fill_and_backpressure();
        write_limit(CFG_PER_CONN, 9'd256);
        write_limit(CFG_PENDING, 9'd511);
        fork
            begin
                sink_hold = 1'b1;
                repeat (3000) @(negedge aclk);
                sink_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < QDEPTH + 4; i++)
            send_request(mk(OP_PUSH, 16'(1 + i % 3), 7, 9, 0, 64'(i + 1)));
        drain_results();
        // sender pauses here until all results are in
        sink_noidle = 1'b1;
        src_noidle = 1'b1;
        for (int i = 0; i < 40; i++) send_request(mk(OP_POP, 0, 0, 0, 0, 0));
        send_request(mk(OP_REMOVE, 2, 0, 0, 0, 0));
        sink_noidle = 1'b0;
        src_noidle = 1'b0;
        send_request(mk(OP_REMOVE, 1, 0, 0, 0, 0));
        send_request(mk(OP_REMOVE, 3, 0, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_random();
        logic [8:0] pc [4] = '{9'd16, 9'd1, 9'd3, 9'd256};
        logic [8:0] pl [4] = '{9'd256, 9'd1, 9'd20, 9'd300};
        for (int phase = 0; phase < 4; phase++) begin
            write_limit(CFG_PER_CONN, pc[phase]);
            write_limit(CFG_PENDING, pl[phase]);
            src_noidle = (phase == 2);
            sink_noidle = (phase == 2);
            for (int i = 0; i < 380; i++) send_request(rand_request());
            drain_results();
        end
        src_noidle = 1'b0;
        sink_noidle = 1'b0;
    endtask

    initial begin
        conn_limit = 9'd16;
        total_limit = 9'd256;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_limits();
        test_fill_and_backpressure();
        test_random();
        drain_results();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire

### admission_controlled_request_fifo.f
design/acrf_pkg.sv
design/acrf_cell.sv
design/admission_controlled_request_fifo.sv
design/acrf_checker.sv
tb/sv/testbench.sv
